>>> hw/rtl/tyd_pkg.sv
// shared constants, register codes and result type for the tiled yuv420 detiler
`default_nettype none

package tyd_pkg;

	localparam int MAX_WIDTH     = 4096;
	localparam int TILE_SIZE     = 16;
	localparam int CHROMA_TILE_H = 8;

	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int BYTE_W   = 8;
	localparam int OFFSET_W = 25;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH       = 3'd0,
		REG_FRAME_HEIGHT      = 3'd1,
		REG_LUMA_DST_STRIDE   = 3'd2,
		REG_CHROMA_DST_STRIDE = 3'd3,
		REG_LUMA_SRC_STRIDE   = 3'd4,
		REG_CHROMA_SRC_STRIDE = 3'd5
	} cfg_reg_t;

	localparam logic [12:0] RST_FRAME_WIDTH       = 13'd1920;
	localparam logic [12:0] RST_FRAME_HEIGHT      = 13'd1088;
	localparam logic [13:0] RST_LUMA_DST_STRIDE   = 14'd1920;
	localparam logic [13:0] RST_CHROMA_DST_STRIDE = 14'd1920;
	localparam logic [17:0] RST_LUMA_SRC_STRIDE   = 18'd30720;
	localparam logic [16:0] RST_CHROMA_SRC_STRIDE = 17'd15360;

	typedef struct packed {
		logic                plane;
		logic [OFFSET_W-1:0] dest_offset;
		logic [BYTE_W-1:0]   pixel_value;
		logic                frame_end;
	} pix_t;

endpackage

`default_nettype wire

>>> hw/rtl/tyd_byte_if.sv
// source byte channel of the detiler
`default_nettype none

interface tyd_byte_if import tyd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] source_byte;

	modport source (output valid, output source_byte, input ready);
	modport sink (input valid, input source_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tyd_pix_if.sv
// destination pixel channel of the detiler
`default_nettype none

interface tyd_pix_if import tyd_pkg::*;;
	logic                valid;
	logic                ready;
	logic                plane;
	logic [OFFSET_W-1:0] dest_offset;
	logic [BYTE_W-1:0]   pixel_value;
	logic                frame_end;

	modport source (output valid, output plane, output dest_offset, output pixel_value,
		output frame_end, input ready);
	modport sink (input valid, input plane, input dest_offset, input pixel_value,
		input frame_end, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tiled_yuv420_to_nv12_detiler.sv
// tiled yuv420 to nv12 detiler: position counters, offset datapath and output skid
//
// usage:
//   tiled  - one source byte per item, frame in memory order: luma tile rows
//            first, then chroma tile rows, each padded up to its source stride
//   linear - one item per content byte: plane, dest_offset, pixel_value and
//            frame_end, which marks the last chroma content byte of a frame
//   apb    - six config registers at byte addresses 0,4,..,20, written by the user
//            only while the block is idle (not enforced); reads return the stored value
// output: a result is registered in the output register, or in the skid entry while
//   linear stalls; padding bytes are consumed and give no result
// throughput: one item per cycle while the skid entry is empty, set by the counter
//   update and the one offset multiplier between the state and output registers
// stall: a two-entry output (register plus skid) keeps tiled.ready high for
//   one more item after linear stops; ready falls while the skid entry is full
// reset: counters go to the start of a luma part, registers to their defaults,
//   both output entries are emptied
`default_nettype none

module tiled_yuv420_to_nv12_detiler import tyd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	tyd_byte_if.sink               tiled,
	tyd_pix_if.source              linear
);

	logic [12:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic [13:0] luma_dst_stride_q;
	logic [13:0] chroma_dst_stride_q;
	logic [17:0] luma_src_stride_q;
	logic [16:0] chroma_src_stride_q;

	logic        in_chroma_q;
	logic [7:0]  tile_row_q;
	logic [17:0] tile_row_position_q;
	logic [7:0]  tile_column_q;
	logic [3:0]  row_in_tile_q;
	logic [3:0]  byte_in_row_q;

	logic        out_valid_q;
	logic        skid_valid_q;
	pix_t        out_q;
	pix_t        skid_q;

	cfg_reg_t    cfg_idx;
	logic        cfg_wr;

	logic [8:0]  cols;
	logic [8:0]  rows;
	logic        frame_empty;
	logic [4:0]  tile_h;
	logic [16:0] content;
	logic [17:0] stride;
	logic [17:0] rowlen;
	logic        has_content;
	logic [17:0] pos_inc;
	logic        row_end;
	logic [8:0]  tr_inc;
	logic        last_row;
	logic [11:0] line;
	logic [13:0] dst_stride;
	logic [25:0] prod;
	logic [3:0]  pos4;
	logic [11:0] col_off;
	logic [3:0]  byte_n;
	logic [3:0]  row_n;
	logic        accept;
	logic        produce;
	pix_t        new_pix;

	// config port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = cfg_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q       <= RST_FRAME_WIDTH;
			frame_height_q      <= RST_FRAME_HEIGHT;
			luma_dst_stride_q   <= RST_LUMA_DST_STRIDE;
			chroma_dst_stride_q <= RST_CHROMA_DST_STRIDE;
			luma_src_stride_q   <= RST_LUMA_SRC_STRIDE;
			chroma_src_stride_q <= RST_CHROMA_SRC_STRIDE;
		end else if (cfg_wr && pready) begin
			unique case (cfg_idx)
				REG_FRAME_WIDTH:       frame_width_q       <= pwdata[12:0];
				REG_FRAME_HEIGHT:      frame_height_q      <= pwdata[12:0];
				REG_LUMA_DST_STRIDE:   luma_dst_stride_q   <= pwdata[13:0];
				REG_CHROMA_DST_STRIDE: chroma_dst_stride_q <= pwdata[13:0];
				REG_LUMA_SRC_STRIDE:   luma_src_stride_q   <= pwdata[17:0];
				REG_CHROMA_SRC_STRIDE: chroma_src_stride_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_FRAME_WIDTH:       prdata = DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT:      prdata = DATA_W'(frame_height_q);
			REG_LUMA_DST_STRIDE:   prdata = DATA_W'(luma_dst_stride_q);
			REG_CHROMA_DST_STRIDE: prdata = DATA_W'(chroma_dst_stride_q);
			REG_LUMA_SRC_STRIDE:   prdata = DATA_W'(luma_src_stride_q);
			REG_CHROMA_SRC_STRIDE: prdata = DATA_W'(chroma_src_stride_q);
			default:               prdata = '0;
		endcase
	end

	// frame geometry
	assign cols = (frame_width_q > 13'(MAX_WIDTH)) ? 9'(MAX_WIDTH / TILE_SIZE)
		: frame_width_q[12:4];
	assign rows = (frame_height_q > 13'(MAX_WIDTH)) ? 9'(MAX_WIDTH / TILE_SIZE)
		: frame_height_q[12:4];
	assign frame_empty = (cols == 9'd0) || (rows == 9'd0);

	assign tile_h  = in_chroma_q ? 5'(CHROMA_TILE_H) : 5'(TILE_SIZE);
	assign content = in_chroma_q ? {1'b0, cols, 7'd0} : {cols, 8'd0};
	assign stride  = in_chroma_q ? {1'b0, chroma_src_stride_q} : luma_src_stride_q;
	assign rowlen  = (stride > {1'b0, content}) ? stride : {1'b0, content};

	assign has_content = tile_row_position_q < {1'b0, content};
	assign pos_inc     = tile_row_position_q + 18'd1;
	assign row_end     = pos_inc >= rowlen;
	assign tr_inc      = {1'b0, tile_row_q} + 9'd1;
	assign last_row    = tr_inc >= rows;

	// destination offset
	assign line = in_chroma_q ? ({1'b0, tile_row_q, 3'd0} + {8'd0, row_in_tile_q})
		: ({tile_row_q, 4'd0} + {8'd0, row_in_tile_q});
	assign dst_stride = in_chroma_q ? chroma_dst_stride_q : luma_dst_stride_q;
	assign prod       = 26'(line) * 26'(dst_stride);
	// chroma u bytes land on even lanes of the tile column, v bytes on odd lanes
	assign pos4       = in_chroma_q ? {byte_in_row_q[2:0], byte_in_row_q[3]} : byte_in_row_q;
	assign col_off    = {tile_column_q, 4'd0} + {8'd0, pos4};

	assign new_pix.plane       = in_chroma_q;
	assign new_pix.dest_offset = prod[OFFSET_W-1:0] + OFFSET_W'(col_off);
	assign new_pix.pixel_value = tiled.source_byte;
	assign new_pix.frame_end   = in_chroma_q && last_row && (pos_inc == {1'b0, content});

	assign accept  = tiled.valid && tiled.ready;
	assign produce = accept && !frame_empty && has_content;

	// position counters
	assign byte_n = byte_in_row_q + 4'd1;
	assign row_n  = row_in_tile_q + 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_chroma_q         <= 1'b0;
			tile_row_q          <= '0;
			tile_row_position_q <= '0;
			tile_column_q       <= '0;
			row_in_tile_q       <= '0;
			byte_in_row_q       <= '0;
		end else if (accept && !frame_empty) begin
			if (row_end) begin
				tile_row_position_q <= '0;
				tile_column_q       <= '0;
				row_in_tile_q       <= '0;
				byte_in_row_q       <= '0;
				if (last_row) begin
					tile_row_q  <= '0;
					in_chroma_q <= ~in_chroma_q;
				end else begin
					tile_row_q <= tr_inc[7:0];
				end
			end else begin
				tile_row_position_q <= pos_inc;
				if (has_content) begin
					byte_in_row_q <= byte_n;
					if (byte_n == 4'd0) begin
						if ({1'b0, row_n} >= tile_h) begin
							row_in_tile_q <= '0;
							tile_column_q <= tile_column_q + 8'd1;
						end else begin
							row_in_tile_q <= row_n;
						end
					end
				end
			end
		end
	end

	// output register and skid entry
	assign tiled.ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (linear.ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= produce;
			end
		end else if (produce) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (linear.ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : new_pix;
		end else if (produce) begin
			skid_q <= new_pix;
		end
	end

	assign linear.valid       = out_valid_q;
	assign linear.plane       = out_q.plane;
	assign linear.dest_offset = out_q.dest_offset;
	assign linear.pixel_value = out_q.pixel_value;
	assign linear.frame_end   = out_q.frame_end;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry full while output register empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !linear.ready))
		else $error("skid entry filled without an output stall");

	a_chroma_rows: assert property (@(posedge clk) disable iff (!arst_n)
		in_chroma_q |-> (row_in_tile_q < 4'(CHROMA_TILE_H)))
		else $error("chroma row counter past tile height");

	a_end_on_chroma: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.frame_end) |-> out_q.plane)
		else $error("frame end flagged on a luma item");

endmodule

`default_nettype wire

>>> tb/tb_tiled_yuv420_to_nv12_detiler.sv
// testbench for the tiled yuv420 to nv12 detiler: directed table, random frames, self-checking
`timescale 1ns / 1ps

module tb_tiled_yuv420_to_nv12_detiler;
	import tyd_pkg::*;

	localparam int HALF_ROW      = TILE_SIZE / 2;
	localparam int NUM_DIR_ROWS  = 30;
	localparam int RANDOM_ITEMS  = 150;
	localparam int STALL_CYCLES  = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 16;
	localparam int END_LIMIT     = 2000;

	typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		cfg_reg_t          cfg_idx;
		logic [DATA_W-1:0] value;
		logic [BYTE_W-1:0] data;
		logic              pinned;
		logic              yields;
		pix_t              px;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	tyd_byte_if tiled_bus ();
	tyd_pix_if  linear_bus ();

	tiled_yuv420_to_nv12_detiler dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tiled   (tiled_bus),
		.linear  (linear_bus)
	);

	// format registers as the block should hold them
	logic [12:0] cfg_width      = RST_FRAME_WIDTH;
	logic [12:0] cfg_height     = RST_FRAME_HEIGHT;
	logic [13:0] cfg_luma_dst   = RST_LUMA_DST_STRIDE;
	logic [13:0] cfg_chroma_dst = RST_CHROMA_DST_STRIDE;
	logic [17:0] cfg_luma_src   = RST_LUMA_SRC_STRIDE;
	logic [16:0] cfg_chroma_src = RST_CHROMA_SRC_STRIDE;

	// walk position through the tiled source frame
	bit          cur_in_chroma   = 1'b0;
	int unsigned cur_tile_row    = 0;
	int unsigned cur_row_pos     = 0;
	int unsigned cur_tile_col    = 0;
	int unsigned cur_row_in_tile = 0;
	int unsigned cur_byte_in_row = 0;

	pix_t      pixel_q [$];
	stim_row_t dir_rows [NUM_DIR_ROWS];
	bit        pin_on;
	bit        pin_yields;
	pix_t      pin_px;
	bit        idle_on;
	bit        hold_req;
	int        errors;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic int unsigned tiles_in(input int unsigned size);
		return (size > MAX_WIDTH ? MAX_WIDTH : size) / TILE_SIZE;
	endfunction

	function automatic bit detile_step(input logic [BYTE_W-1:0] b, output pix_t px);
		int unsigned cols, rows, tile_h, content, row_len, off, lane;
		bit          hit;
		cols = tiles_in(cfg_width);
		rows = tiles_in(cfg_height);
		px = '0;
		hit = 1'b0;
		if (cols == 0 || rows == 0) begin
			return 1'b0;
		end
		tile_h = cur_in_chroma ? CHROMA_TILE_H : TILE_SIZE;
		content = cols * TILE_SIZE * tile_h;
		row_len = cur_in_chroma ? cfg_chroma_src : cfg_luma_src;
		if (content > row_len) begin
			row_len = content;
		end
		if (cur_row_pos < content) begin
			if (!cur_in_chroma) begin
				off = (cur_tile_row * TILE_SIZE + cur_row_in_tile) * cfg_luma_dst +
					cur_tile_col * TILE_SIZE + cur_byte_in_row;
			end else begin
				// u bytes land on even lanes, v bytes on odd lanes
				lane = cur_byte_in_row < HALF_ROW ? 2 * cur_byte_in_row :
					2 * (cur_byte_in_row - HALF_ROW) + 1;
				off = (cur_tile_row * CHROMA_TILE_H + cur_row_in_tile) * cfg_chroma_dst +
					cur_tile_col * TILE_SIZE + lane;
			end
			px.plane = cur_in_chroma;
			px.dest_offset = off[OFFSET_W-1:0];
			px.pixel_value = b;
			px.frame_end = cur_in_chroma && (cur_tile_row + 1 >= rows) &&
				(cur_row_pos + 1 == content);
			hit = 1'b1;
			cur_byte_in_row = (cur_byte_in_row + 1) % TILE_SIZE;
			if (cur_byte_in_row == 0) begin
				cur_row_in_tile = (cur_row_in_tile + 1) % TILE_SIZE;
				if (cur_row_in_tile >= tile_h) begin
					cur_row_in_tile = 0;
					cur_tile_col = (cur_tile_col + 1) % 256;
				end
			end
		end
		cur_row_pos++;
		if (cur_row_pos >= row_len) begin
			cur_row_pos = 0;
			cur_tile_col = 0;
			cur_row_in_tile = 0;
			cur_byte_in_row = 0;
			cur_tile_row++;
			if (cur_tile_row >= rows) begin
				cur_tile_row = 0;
				cur_in_chroma = !cur_in_chroma;
			end
		end
		return hit;
	endfunction

	// source bytes left until the next frame starts with luma
	function automatic int unsigned bytes_to_frame_start();
		int unsigned cols, rows, luma_len, chroma_len, cur_len, n;
		cols = tiles_in(cfg_width);
		rows = tiles_in(cfg_height);
		if (cols == 0 || rows == 0) begin
			return 0;
		end
		luma_len = cols * TILE_SIZE * TILE_SIZE;
		if (cfg_luma_src > luma_len) begin
			luma_len = cfg_luma_src;
		end
		chroma_len = cols * TILE_SIZE * CHROMA_TILE_H;
		if (cfg_chroma_src > chroma_len) begin
			chroma_len = cfg_chroma_src;
		end
		cur_len = cur_in_chroma ? chroma_len : luma_len;
		n = cur_row_pos >= cur_len ? 1 : cur_len - cur_row_pos;
		if (cur_tile_row + 1 < rows) begin
			n += (rows - 1 - cur_tile_row) * cur_len;
		end
		if (!cur_in_chroma) begin
			n += rows * chroma_len;
		end
		return n;
	endfunction

	function automatic int draw_gap();
		return idle_on ? $urandom_range(0, 7) : 0;
	endfunction

	function automatic stim_row_t dir_byte(input logic [BYTE_W-1:0] b);
		stim_row_t r;
		r = '0;
		r.kind = ROW_BYTE;
		r.data = b;
		return r;
	endfunction

	function automatic stim_row_t dir_pin(input logic [BYTE_W-1:0] b, input logic yields,
		input logic plane, input int unsigned off, input logic last);
		stim_row_t r;
		r = dir_byte(b);
		r.pinned = 1'b1;
		r.yields = yields;
		r.px.plane = plane;
		r.px.dest_offset = off[OFFSET_W-1:0];
		r.px.pixel_value = b;
		r.px.frame_end = last;
		return r;
	endfunction

	function automatic stim_row_t dir_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] value);
		stim_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.cfg_idx = idx;
		r.value = value;
		return r;
	endfunction

	task automatic flag(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("%s", msg);
		end
	endtask

	always @(posedge clk) begin : scoreboard
		pix_t px, want, got;
		bit   hit;
		if (arst_n) begin
			if (tiled_bus.valid && tiled_bus.ready) begin
				hit = detile_step(tiled_bus.source_byte, px);
				if (pin_on) begin
					hit = pin_yields;
					px = pin_px;
				end
				if (hit) begin
					pixel_q.push_back(px);
				end
			end
			if (linear_bus.valid && linear_bus.ready) begin
				got.plane = linear_bus.plane;
				got.dest_offset = linear_bus.dest_offset;
				got.pixel_value = linear_bus.pixel_value;
				got.frame_end = linear_bus.frame_end;
				if (pixel_q.size() == 0) begin
					flag($sformatf("unexpected item: plane %0d offset %0d value %0h end %0d",
						got.plane, got.dest_offset, got.pixel_value, got.frame_end));
				end else begin
					want = pixel_q.pop_front();
					if (got.plane !== want.plane || got.dest_offset !== want.dest_offset ||
						got.pixel_value !== want.pixel_value ||
						got.frame_end !== want.frame_end) begin
						flag($sformatf({"item mismatch: expected plane %0d offset %0d ",
							"value %0h end %0d, got plane %0d offset %0d value %0h end %0d"},
							want.plane, want.dest_offset, want.pixel_value, want.frame_end,
							got.plane, got.dest_offset, got.pixel_value, got.frame_end));
					end
				end
			end
		end
	end

	initial begin : receiver
		int gap;
		linear_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (hold_req) begin
				linear_bus.ready <= 1'b0;
				repeat (STALL_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (gap > 0) begin
				linear_bus.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			linear_bus.ready <= 1'b1;
			do @(posedge clk); while (!linear_bus.valid);
			@(negedge clk);
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			tiled_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tiled_bus.valid <= 1'b1;
		tiled_bus.source_byte <= b;
		do @(posedge clk); while (!tiled_bus.ready);
		@(negedge clk);
	endtask

	task automatic send_run(input int unsigned n);
		int unsigned k;
		for (k = 0; k < n; k++) begin
			send_byte($urandom_range(0, 255));
		end
	endtask

	task automatic settle();
		tiled_bus.valid <= 1'b0;
		while (pixel_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] stored;
		settle();
		case (idx)
			REG_FRAME_WIDTH: begin
				cfg_width = value[12:0];
				stored = value & 32'h1FFF;
			end
			REG_FRAME_HEIGHT: begin
				cfg_height = value[12:0];
				stored = value & 32'h1FFF;
			end
			REG_LUMA_DST_STRIDE: begin
				cfg_luma_dst = value[13:0];
				stored = value & 32'h3FFF;
			end
			REG_CHROMA_DST_STRIDE: begin
				cfg_chroma_dst = value[13:0];
				stored = value & 32'h3FFF;
			end
			REG_LUMA_SRC_STRIDE: begin
				cfg_luma_src = value[17:0];
				stored = value & 32'h3FFFF;
			end
			default: begin
				cfg_chroma_src = value[16:0];
				stored = value & 32'h1FFFF;
			end
		endcase
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== stored) begin
			flag($sformatf("register %s read back %0h, expected %0h", idx.name(), prdata,
				stored));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic pick_small_format();
		int unsigned cols, rows, luma_len, chroma_len;
		cols = ($urandom_range(0, 5) == 0) ? 2 : 1;
		rows = ($urandom_range(0, 5) == 0) ? 2 : 1;
		luma_len = cols * TILE_SIZE * TILE_SIZE;
		chroma_len = cols * TILE_SIZE * CHROMA_TILE_H;
		write_reg(REG_FRAME_WIDTH, cols * TILE_SIZE + $urandom_range(0, TILE_SIZE - 1));
		write_reg(REG_FRAME_HEIGHT, rows * TILE_SIZE + $urandom_range(0, TILE_SIZE - 1));
		write_reg(REG_LUMA_DST_STRIDE, $urandom_range(0, 16383));
		write_reg(REG_CHROMA_DST_STRIDE, $urandom_range(0, 16383));
		write_reg(REG_LUMA_SRC_STRIDE, $urandom_range(0, 1) ? $urandom_range(0, luma_len) :
			luma_len + $urandom_range(0, 64));
		write_reg(REG_CHROMA_SRC_STRIDE, $urandom_range(0, 1) ? $urandom_range(0, chroma_len) :
			chroma_len + $urandom_range(0, 64));
	endtask

	initial begin : stimulus
		int          i;
		int unsigned n;
		int unsigned random_sent;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tiled_bus.valid = 1'b0;
		tiled_bus.source_byte = '0;
		pin_on = 1'b0;
		pin_yields = 1'b0;
		pin_px = '0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		errors = 0;
		random_sent = 0;
		dir_rows = '{
			dir_pin(8'h00, 1'b1, 1'b0, 0, 1'b0),
			dir_pin(8'hFF, 1'b1, 1'b0, 1, 1'b0),
			dir_byte(8'h5A),
			dir_byte(8'hA5),
			dir_reg(REG_FRAME_WIDTH, 0),
			dir_pin(8'h3C, 1'b0, 1'b0, 0, 1'b0),
			dir_reg(REG_FRAME_WIDTH, 15),
			dir_pin(8'hC3, 1'b0, 1'b0, 0, 1'b0),
			dir_reg(REG_FRAME_WIDTH, 1920),
			dir_reg(REG_FRAME_HEIGHT, 15),
			dir_pin(8'h01, 1'b0, 1'b0, 0, 1'b0),
			dir_reg(REG_FRAME_HEIGHT, 8191),
			dir_reg(REG_FRAME_WIDTH, 8191),
			dir_pin(8'h80, 1'b1, 1'b0, 4, 1'b0),
			dir_reg(REG_LUMA_DST_STRIDE, 16383),
			dir_byte(8'h7F),
			dir_reg(REG_LUMA_DST_STRIDE, 0),
			dir_byte(8'h12),
			dir_reg(REG_FRAME_WIDTH, 16),
			dir_reg(REG_FRAME_HEIGHT, 16),
			dir_reg(REG_LUMA_SRC_STRIDE, 0),
			dir_reg(REG_CHROMA_SRC_STRIDE, 0),
			dir_byte(8'hE7),
			dir_byte(8'h18),
			dir_reg(REG_CHROMA_DST_STRIDE, 16383),
			dir_reg(REG_LUMA_SRC_STRIDE, 262143),
			dir_reg(REG_CHROMA_SRC_STRIDE, 131071),
			dir_byte(8'h99),
			dir_byte(8'h66),
			dir_reg(REG_CHROMA_DST_STRIDE, 0)
		};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < NUM_DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_REG) begin
				write_reg(dir_rows[i].cfg_idx, dir_rows[i].value);
			end else begin
				pin_on = dir_rows[i].pinned;
				pin_yields = dir_rows[i].yields;
				pin_px = dir_rows[i].px;
				send_byte(dir_rows[i].data);
			end
		end
		pin_on = 1'b0;

		// back up the output while bytes keep coming, then finish the frame
		pick_small_format();
		settle();
		idle_on = 1'b0;
		hold_req = 1'b1;
		send_run(bytes_to_frame_start());

		while (random_sent < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 4) != 0);
			case ($urandom_range(0, 9))
				0: begin
					write_reg($urandom_range(0, 1) ? REG_FRAME_WIDTH : REG_FRAME_HEIGHT,
						$urandom_range(0, TILE_SIZE - 1));
					send_run($urandom_range(1, 8));
				end
				1, 2, 3: begin
					pick_small_format();
					n = $urandom_range(1, 120);
					if (n > RANDOM_ITEMS - random_sent) begin
						n = RANDOM_ITEMS - random_sent;
					end
					send_run(n);
					random_sent += n;
				end
				default: begin
					pick_small_format();
					n = bytes_to_frame_start();
					if (n > RANDOM_ITEMS - random_sent) begin
						n = RANDOM_ITEMS - random_sent;
					end
					send_run(n);
					random_sent += n;
				end
			endcase
		end

		tiled_bus.valid <= 1'b0;
		for (i = 0; i < END_LIMIT && pixel_q.size() != 0; i++) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pixel_q.size() != 0) begin
			flag($sformatf("%0d expected items never arrived", pixel_q.size()));
		end
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
